// File: rtl/core/assert_macros.svh
// -----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the checker module.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every rising edge, reset included
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/imcc_pkg.sv
// -----------------------------------------------------------------------------
// imcc_pkg
// Types, codes and magic tables for the image magic and PNG chunk checker.
// -----------------------------------------------------------------------------
package imcc_pkg;

  // result codes
  localparam logic [1:0] FMT_NONE   = 2'd0;
  localparam logic [1:0] FMT_PNG    = 2'd1;
  localparam logic [1:0] FMT_JPEG   = 2'd2;
  localparam logic [1:0] FMT_GIF    = 2'd3;

  localparam logic [1:0] V_OK       = 2'd0;
  localparam logic [1:0] V_NOMAGIC  = 2'd1;
  localparam logic [1:0] V_TOOLARGE = 2'd2;
  localparam logic [1:0] V_OVERRUN  = 2'd3;

  localparam int PNG_SIG_LEN  = 8;
  localparam int JPEG_SIG_LEN = 3;
  localparam int GIF_SIG_LEN  = 6;
  localparam int GIF_VER_POS  = 4;
  localparam int HDR_LEN_BYTES = 4;

  localparam int CHUNK_OVERHEAD = 12;
  localparam int HEADER_BYTES   = 8;
  localparam logic [31:0] SKIP_EXTRA = 32'(CHUNK_OVERHEAD - HEADER_BYTES);
  localparam logic [31:0] IEND_TYPE  = 32'h4945_4E44;

  // candidate bit positions
  localparam int CAND_PNG  = 0;
  localparam int CAND_JPEG = 1;
  localparam int CAND_GIF  = 2;

  localparam int OBUF_DEPTH_DEF = 2;

  typedef enum logic [3:0] {
    PH_SIG  = 4'b0001,
    PH_HDR  = 4'b0010,
    PH_SKIP = 4'b0100,
    PH_DONE = 4'b1000
  } phase_t;

  typedef struct packed {
    logic       vld;
    logic [1:0] fmt;
    logic [1:0] verdict;
  } res_t;

  function automatic logic [7:0] png_sig_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0: b = 8'h89;
      3'd1: b = 8'h50;
      3'd2: b = 8'h4E;
      3'd3: b = 8'h47;
      3'd4: b = 8'h0D;
      3'd5: b = 8'h0A;
      3'd6: b = 8'h1A;
      3'd7: b = 8'h0A;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] jpeg_sig_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0: b = 8'hFF;
      2'd1: b = 8'hD8;
      2'd2: b = 8'hFF;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // position 4 is the version digit, handled by the caller
  function automatic logic [7:0] gif_sig_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0: b = 8'h47;
      3'd1: b = 8'h49;
      3'd2: b = 8'h46;
      3'd3: b = 8'h38;
      3'd5: b = 8'h61;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: rtl/core/imcc_if.sv
// -----------------------------------------------------------------------------
// imcc channel interfaces
// Valid/ready channels for file bytes in and verdicts out.
// -----------------------------------------------------------------------------
interface imcc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface imcc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] image_format;
  logic [1:0] verdict;

  modport source (output valid, output image_format, output verdict, input ready);
  modport sink   (input valid, input image_format, input verdict, output ready);
endinterface

// File: rtl/core/imcc_core.sv
// -----------------------------------------------------------------------------
// imcc_core
// Per-byte state update: magic classification and PNG chunk header walk.
// -----------------------------------------------------------------------------
module imcc_core
  import imcc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  logic [7:0] data_byte,
  input  logic       final_byte,
  output res_t       res
);

  phase_t      phase_r, phase_nxt;
  logic [2:0]  sig_cnt_r, sig_cnt_nxt;
  logic [2:0]  cand_r, cand_nxt;
  logic [2:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [31:0] chunk_len_r, chunk_len_nxt;
  logic [31:0] chunk_type_r, chunk_type_nxt;
  logic [31:0] skip_r, skip_nxt;

  logic        png_ok, jpeg_ok, gif_ok;
  logic [2:0]  cand_m;
  logic [31:0] skip_dec;
  res_t        res_c;

  assign skip_dec = skip_r - 32'd1;

  always_comb begin
    png_ok  = (data_byte == png_sig_byte(sig_cnt_r));
    jpeg_ok = (sig_cnt_r < 3'(JPEG_SIG_LEN)) && (data_byte == jpeg_sig_byte(sig_cnt_r[1:0]));
    if (sig_cnt_r == 3'(GIF_VER_POS)) begin
      gif_ok = (data_byte == 8'h37) || (data_byte == 8'h39);
    end else begin
      gif_ok = (sig_cnt_r < 3'(GIF_SIG_LEN)) && (data_byte == gif_sig_byte(sig_cnt_r));
    end
    cand_m = cand_r;
    cand_m[CAND_PNG]  = cand_r[CAND_PNG] & png_ok;
    cand_m[CAND_JPEG] = cand_r[CAND_JPEG] & jpeg_ok;
    cand_m[CAND_GIF]  = cand_r[CAND_GIF] & gif_ok;
  end

  always_comb begin
    phase_nxt      = phase_r;
    sig_cnt_nxt    = sig_cnt_r;
    cand_nxt       = cand_r;
    hdr_cnt_nxt    = hdr_cnt_r;
    chunk_len_nxt  = chunk_len_r;
    chunk_type_nxt = chunk_type_r;
    skip_nxt       = skip_r;
    res_c          = '0;

    unique case (phase_r)
      PH_SIG: begin
        cand_nxt    = cand_m;
        sig_cnt_nxt = sig_cnt_r + 3'd1;
        priority if (cand_m == 3'b000) begin
          res_c = '{vld: 1'b1, fmt: FMT_NONE, verdict: V_NOMAGIC};
        end else if (cand_m[CAND_JPEG] && sig_cnt_r == 3'(JPEG_SIG_LEN - 1)) begin
          res_c = '{vld: 1'b1, fmt: FMT_JPEG, verdict: V_OK};
        end else if (cand_m[CAND_GIF] && sig_cnt_r == 3'(GIF_SIG_LEN - 1)) begin
          res_c = '{vld: 1'b1, fmt: FMT_GIF, verdict: V_OK};
        end else if (cand_m[CAND_PNG] && sig_cnt_r == 3'(PNG_SIG_LEN - 1)) begin
          phase_nxt   = PH_HDR;
          hdr_cnt_nxt = 3'd0;
          if (final_byte) begin
            res_c = '{vld: 1'b1, fmt: FMT_PNG, verdict: V_OK};
          end
        end else if (final_byte) begin
          res_c = '{vld: 1'b1, fmt: FMT_NONE, verdict: V_NOMAGIC};
        end
      end
      PH_HDR: begin
        if (hdr_cnt_r < 3'(HDR_LEN_BYTES)) begin
          chunk_len_nxt = {chunk_len_r[23:0], data_byte};
        end else begin
          chunk_type_nxt = {chunk_type_r[23:0], data_byte};
        end
        hdr_cnt_nxt = hdr_cnt_r + 3'd1;
        if (hdr_cnt_r != 3'(HEADER_BYTES - 1)) begin
          // file ending inside a header is let through
          if (final_byte) begin
            res_c = '{vld: 1'b1, fmt: FMT_PNG, verdict: V_OK};
          end
        end else if (chunk_len_r[31]) begin
          res_c = '{vld: 1'b1, fmt: FMT_PNG, verdict: V_TOOLARGE};
        end else if (final_byte) begin
          res_c = '{vld: 1'b1, fmt: FMT_PNG, verdict: V_OVERRUN};
        end else begin
          skip_nxt  = chunk_len_r + SKIP_EXTRA;
          phase_nxt = PH_SKIP;
        end
      end
      PH_SKIP: begin
        skip_nxt = skip_dec;
        if (skip_dec == 32'd0) begin
          if (chunk_type_r == IEND_TYPE || final_byte) begin
            res_c = '{vld: 1'b1, fmt: FMT_PNG, verdict: V_OK};
          end else begin
            phase_nxt      = PH_HDR;
            hdr_cnt_nxt    = 3'd0;
            chunk_len_nxt  = 32'd0;
            chunk_type_nxt = 32'd0;
          end
        end else if (final_byte) begin
          res_c = '{vld: 1'b1, fmt: FMT_PNG, verdict: V_OVERRUN};
        end
      end
      PH_DONE: begin
        // swallow bytes until the last one
      end
      default: begin
        phase_nxt = PH_DONE;
      end
    endcase

    if (res_c.vld) begin
      phase_nxt = PH_DONE;
    end
  end

  assign res = '{vld: acc & res_c.vld, fmt: res_c.fmt, verdict: res_c.verdict};

  always_ff @(posedge clk) begin
    if (!rst_n || (acc && final_byte)) begin
      phase_r      <= PH_SIG;
      sig_cnt_r    <= 3'd0;
      cand_r       <= 3'b111;
      hdr_cnt_r    <= 3'd0;
      chunk_len_r  <= 32'd0;
      chunk_type_r <= 32'd0;
      skip_r       <= 32'd0;
    end else if (acc) begin
      phase_r      <= phase_nxt;
      sig_cnt_r    <= sig_cnt_nxt;
      cand_r       <= cand_nxt;
      hdr_cnt_r    <= hdr_cnt_nxt;
      chunk_len_r  <= chunk_len_nxt;
      chunk_type_r <= chunk_type_nxt;
      skip_r       <= skip_nxt;
    end
  end

endmodule

// File: rtl/core/imcc_obuf.sv
// -----------------------------------------------------------------------------
// imcc_obuf
// Small result queue: a DEPTH-entry circular buffer, read at its head.
// -----------------------------------------------------------------------------
module imcc_obuf
  import imcc_pkg::*;
#(
  parameter int DEPTH = OBUF_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  res_t push,
  output logic space,
  imcc_out_if.source out_ch
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [3:0]    mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pop;

  assign pop     = out_ch.valid & out_ch.ready;
  assign cnt_nxt = cnt_r + CW'(push.vld) - CW'(pop);
  assign space   = (cnt_r < CW'(DEPTH));

  assign out_ch.valid        = (cnt_r != '0);
  assign out_ch.image_format = mem[rd_ptr_r][3:2];
  assign out_ch.verdict      = mem[rd_ptr_r][1:0];

  always_ff @(posedge clk) begin
    if (push.vld) begin
      mem[wr_ptr_r] <= {push.fmt, push.verdict};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push.vld) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/image_magic_and_png_chunk_checker.sv
// -----------------------------------------------------------------------------
// image_magic_and_png_chunk_checker
// Streams file bytes, classifies PNG/JPEG/GIF magic, walks PNG chunk headers.
// -----------------------------------------------------------------------------
// Channel  Dir  Payload                         Beat
// in_ch    in   data_byte[7:0], final_byte      one file byte
// out_ch   out  image_format[1:0], verdict[1:0] one verdict per file
//
// One byte per cycle while the result queue has space; each beat updates the
// checker state in the cycle it is taken and any verdict is written to the
// result queue at the same edge, which presents results on out_ch in order.
// in_ch.ready drops only when the OBUF_DEPTH-entry result queue is full.
// Synchronous active-low reset; the last byte of a file re-arms the checker.
// -----------------------------------------------------------------------------
module image_magic_and_png_chunk_checker
  import imcc_pkg::*;
#(
  parameter int OBUF_DEPTH = OBUF_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  imcc_in_if.sink    in_ch,
  imcc_out_if.source out_ch
);

  logic acc;
  logic space;
  res_t res;

  assign in_ch.ready = space;
  assign acc         = in_ch.valid & space;

  imcc_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .data_byte  (in_ch.data_byte),
    .final_byte (in_ch.final_byte),
    .res        (res)
  );

  imcc_obuf #(
    .DEPTH (OBUF_DEPTH)
  ) u_obuf (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (res),
    .space  (space),
    .out_ch (out_ch)
  );

endmodule

// File: rtl/core/imcc_checker.sv
// -----------------------------------------------------------------------------
// imcc_checker
// Port-level assertions on the checker's result channel.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module imcc_checker
  import imcc_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_format,
  input logic [1:0] out_verdict
);

  // a stalled verdict keeps its payload
  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_format) && $stable(out_verdict), "stalled result changed")

  // no format exactly when no magic matched
  `ASSERT_CLK(a_fmt_none, out_valid |-> ((out_format == FMT_NONE) == (out_verdict == V_NOMAGIC)), "format and magic verdict disagree")

  // chunk failures only come from a PNG walk
  `ASSERT_CLK(a_chunk_png, out_valid && (out_verdict == V_TOOLARGE || out_verdict == V_OVERRUN) |-> out_format == FMT_PNG, "chunk verdict on non-PNG")

  // reset empties the result queue
  `ASSERT_CLK_ALWAYS(a_rst_empty, !rst_n |=> !out_valid, "result present after reset")

endmodule

bind image_magic_and_png_chunk_checker imcc_checker u_imcc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_format  (out_ch.image_format),
  .out_verdict (out_ch.verdict)
);
